FILE: rtl/table_linear_interpolation_lookup_defines.svh
// assertion macros shared by the rtl files
// define ASSERT_OFF to compile the checks away
`ifndef TABLE_LINEAR_INTERPOLATION_LOOKUP_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATION_LOOKUP_DEFINES_SVH

`ifndef ASSERT_OFF
// check a property on the rising clock edge, off while in reset
`define TLIL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on the rising clock edge, reset included
`define TLIL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLIL_ASSERT(lbl, clk, rst, prop, msg)
`define TLIL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/tlil_pkg.sv
`timescale 1ns / 1ps

package tlil_pkg;

  // table geometry and field widths
  localparam int TABLE_DEPTH = 16;
  localparam int DATA_W      = 48;
  localparam int CFG_W       = 5;
  localparam int IDX_IN_W    = 4;
  localparam int STAT_W      = 3;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int MD_CNT_W    = $clog2(DATA_W);
  localparam int MIN_ENTRIES = 2;

  localparam logic [CFG_W-1:0]  ENTRIES_RESET = CFG_W'(14);
  localparam logic [DATA_W-1:0] SIGN_BIT      = {1'b1, {(DATA_W-1){1'b0}}};

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] STAT_INTERP = 3'd0;
  localparam logic [STAT_W-1:0] STAT_HIT    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BELOW  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ABOVE  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_WRITE  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_PREP = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  typedef struct packed {
    logic                     cmd;
    logic [IDX_IN_W-1:0]      entry_index;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [STAT_W-1:0]        status;
  } rsp_t;

  // operands of the multiply-divide unit, all offset-binary differences
  typedef struct packed {
    logic [DATA_W-1:0] dy;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] d;
  } md_op_t;

  // signed value to offset binary, so unsigned compare gives signed order
  function automatic logic [DATA_W-1:0] to_biased(input logic signed [DATA_W-1:0] v);
    return DATA_W'(v) ^ SIGN_BIT;
  endfunction

  function automatic logic signed [DATA_W-1:0] from_biased(input logic [DATA_W-1:0] v);
    return signed'(v ^ SIGN_BIT);
  endfunction

endpackage

FILE: rtl/tlil_muldiv.sv
`timescale 1ns / 1ps

// floor(dy * t / d) for t < d, one bit of dy per cycle
module tlil_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  tlil_pkg::md_op_t op,
  output logic             done,
  output logic [tlil_pkg::DATA_W-1:0] q
);

  localparam int W = tlil_pkg::DATA_W;

  logic                        run;
  logic [tlil_pkg::MD_CNT_W-1:0] cnt;
  logic [W-1:0]                dy_sh;
  logic [W-1:0]                t_r;
  logic [W-1:0]                d_r;
  logic [W:0]                  d2_r;
  logic [W-1:0]                rem;
  logic [W-1:0]                quo;

  logic [W+1:0] sum;
  logic [W+1:0] sub1;
  logic [W+1:0] sub2;
  logic         ge1;
  logic         ge2;
  logic [W-1:0] rem_next;
  logic [W-1:0] quo_next;

  // running remainder stays below d, so 2r + t stays below 3d
  always_comb begin
    sum  = {1'b0, rem, 1'b0} + {2'b00, t_r & {W{dy_sh[W-1]}}};
    sub1 = sum - {2'b00, d_r};
    sub2 = sum - {1'b0, d2_r};
    ge2  = (sum >= {1'b0, d2_r});
    ge1  = (sum >= {2'b00, d_r});
    if (ge2) begin
      rem_next = sub2[W-1:0];
      quo_next = {quo[W-2:0], 1'b0} + W'(2);
    end else if (ge1) begin
      rem_next = sub1[W-1:0];
      quo_next = {quo[W-2:0], 1'b1};
    end else begin
      rem_next = sum[W-1:0];
      quo_next = {quo[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
      end else if (run && cnt == tlil_pkg::MD_CNT_W'(W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dy_sh <= op.dy;
      t_r   <= op.t;
      d_r   <= op.d;
      d2_r  <= {op.d, 1'b0};
      rem   <= '0;
      quo   <= '0;
      cnt   <= '0;
    end else if (run) begin
      dy_sh <= {dy_sh[W-2:0], 1'b0};
      rem   <= rem_next;
      quo   <= quo_next;
      cnt   <= cnt + 1'b1;
    end
  end

  assign q = quo;

endmodule

FILE: rtl/table_linear_interpolation_lookup.sv
`timescale 1ns / 1ps
// write: result strobe in the cycle after the transfer, busy never rises
// lookup: the scan reads the first n entries in turn (n = clamped entry count); an exact hit,
//   a clamp or equal neighbour values give the strobe from the prep state, any other
//   interpolation when the 48-step shift-subtract multiply-divide unit is done
// busy stays high until the strobe, the next transfer may land in the strobe cycle
// reset: sequencer idle, no strobe, entry count back to 14; table contents undefined
`include "table_linear_interpolation_lookup_defines.svh"

module table_linear_interpolation_lookup (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tlil_pkg::req_t                req,
  output logic                          done,
  output tlil_pkg::rsp_t                rsp,
  input  logic                          cfg_we,
  input  logic [tlil_pkg::CFG_W-1:0]    cfg_data
);

  localparam int W = tlil_pkg::DATA_W;

  tlil_pkg::state_t state;

  // configuration
  logic [tlil_pkg::CFG_W-1:0] entries_in_use;
  logic [tlil_pkg::CNT_W-1:0] n_clamp;

  // table, keys and values held in offset binary
  logic [W-1:0] key_store   [tlil_pkg::TABLE_DEPTH];
  logic [W-1:0] value_store [tlil_pkg::TABLE_DEPTH];
  logic [W-1:0] rd_key;
  logic [W-1:0] rd_val;
  logic         rd_vld;

  // lookup context
  logic [W-1:0]               k_r;
  logic [tlil_pkg::CNT_W-1:0] n_r;
  logic [tlil_pkg::CNT_W-1:0] scan_cnt;
  logic                       hit;
  logic [W-1:0]               hit_val;
  logic                       have_lo;
  logic [W-1:0]               x1;
  logic [W-1:0]               y1;
  logic                       have_hi;
  logic [W-1:0]               x2;
  logic [W-1:0]               y2;
  logic                       up_r;

  logic accept;
  logic wr_en;
  logic interp;
  logic up;
  logic key_lt;
  logic key_eq;

  tlil_pkg::md_op_t      md_op;
  logic                  md_go;
  logic                  md_done;
  logic [W-1:0]          md_q;
  logic [W-1:0]          interp_res;

  assign busy   = (state != tlil_pkg::S_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (req.cmd == tlil_pkg::CMD_WRITE) &&
                  ({1'b0, req.entry_index} < (tlil_pkg::IDX_IN_W + 1)'(tlil_pkg::TABLE_DEPTH));

  // entry count clamped to [2, depth] when a lookup is taken
  always_comb begin
    if (int'(entries_in_use) < tlil_pkg::MIN_ENTRIES) begin
      n_clamp = tlil_pkg::CNT_W'(tlil_pkg::MIN_ENTRIES);
    end else if (int'(entries_in_use) > tlil_pkg::TABLE_DEPTH) begin
      n_clamp = tlil_pkg::CNT_W'(tlil_pkg::TABLE_DEPTH);
    end else begin
      n_clamp = tlil_pkg::CNT_W'(entries_in_use);
    end
  end

  // table ram, registered read at the scan address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_store[tlil_pkg::IDX_W'(req.entry_index)]   <= tlil_pkg::to_biased(req.key);
      value_store[tlil_pkg::IDX_W'(req.entry_index)] <= tlil_pkg::to_biased(req.entry_value);
    end
    rd_key <= key_store[scan_cnt[tlil_pkg::IDX_W-1:0]];
    rd_val <= value_store[scan_cnt[tlil_pkg::IDX_W-1:0]];
  end

  // per-entry compares against the lookup key
  assign key_lt = (rd_key < k_r);
  assign key_eq = (rd_key == k_r);

  // interpolation needed only when both neighbors exist and their values differ
  assign interp = !hit && have_lo && have_hi && (y1 != y2);

  // operand setup for the multiply-divide unit
  always_comb begin
    up       = (y2 > y1);
    md_op.dy = up ? (y2 - y1) : (y1 - y2);
    md_op.t  = k_r - x1;
    md_op.d  = x2 - x1;
  end
  assign md_go = (state == tlil_pkg::S_PREP) && interp;

  assign interp_res = up_r ? (y1 + md_q) : (y1 - md_q);

  tlil_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .go   (md_go),
    .op   (md_op),
    .done (md_done),
    .q    (md_q)
  );

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tlil_pkg::S_IDLE;
      done           <= 1'b0;
      rd_vld         <= 1'b0;
      entries_in_use <= tlil_pkg::ENTRIES_RESET;
    end else begin
      done   <= 1'b0;
      rd_vld <= (state == tlil_pkg::S_SCAN) && (scan_cnt != n_r);
      if (cfg_we) begin
        entries_in_use <= cfg_data;
      end
      case (state)
        tlil_pkg::S_IDLE: begin
          if (accept) begin
            if (req.cmd == tlil_pkg::CMD_WRITE) begin
              done <= 1'b1;
            end else begin
              state <= tlil_pkg::S_SCAN;
            end
          end
        end
        tlil_pkg::S_SCAN: begin
          // all reads issued and the last one consumed
          if (scan_cnt == n_r && !rd_vld) begin
            state <= tlil_pkg::S_PREP;
          end
        end
        tlil_pkg::S_PREP: begin
          if (interp) begin
            state <= tlil_pkg::S_DIV;
          end else begin
            done  <= 1'b1;
            state <= tlil_pkg::S_IDLE;
          end
        end
        tlil_pkg::S_DIV: begin
          if (md_done) begin
            done  <= 1'b1;
            state <= tlil_pkg::S_IDLE;
          end
        end
        default: begin
          state <= tlil_pkg::S_IDLE;
        end
      endcase
    end
  end

  // lookup datapath and result register
  always_ff @(posedge clk) begin
    case (state)
      tlil_pkg::S_IDLE: begin
        if (accept) begin
          k_r      <= tlil_pkg::to_biased(req.key);
          n_r      <= n_clamp;
          scan_cnt <= '0;
          hit      <= 1'b0;
          have_lo  <= 1'b0;
          have_hi  <= 1'b0;
          if (req.cmd == tlil_pkg::CMD_WRITE) begin
            rsp.result_value <= '0;
            rsp.status       <= tlil_pkg::STAT_WRITE;
          end
        end
      end
      tlil_pkg::S_SCAN: begin
        if (scan_cnt != n_r) begin
          scan_cnt <= scan_cnt + 1'b1;
        end
        if (rd_vld) begin
          // lowest index wins on ties, hence strict compares
          if (key_eq && !hit) begin
            hit     <= 1'b1;
            hit_val <= rd_val;
          end
          if (key_lt) begin
            if (!have_lo || rd_key > x1) begin
              have_lo <= 1'b1;
              x1      <= rd_key;
              y1      <= rd_val;
            end
          end else begin
            if (!have_hi || rd_key < x2) begin
              have_hi <= 1'b1;
              x2      <= rd_key;
              y2      <= rd_val;
            end
          end
        end
      end
      tlil_pkg::S_PREP: begin
        up_r <= up;
        if (hit) begin
          rsp.result_value <= tlil_pkg::from_biased(hit_val);
          rsp.status       <= tlil_pkg::STAT_HIT;
        end else if (!have_lo) begin
          rsp.result_value <= tlil_pkg::from_biased(y2);
          rsp.status       <= tlil_pkg::STAT_BELOW;
        end else if (!have_hi) begin
          rsp.result_value <= tlil_pkg::from_biased(y1);
          rsp.status       <= tlil_pkg::STAT_ABOVE;
        end else begin
          // equal neighbor values, no division needed
          rsp.result_value <= tlil_pkg::from_biased(y2);
          rsp.status       <= tlil_pkg::STAT_INTERP;
        end
      end
      tlil_pkg::S_DIV: begin
        if (md_done) begin
          rsp.result_value <= tlil_pkg::from_biased(interp_res);
          rsp.status       <= tlil_pkg::STAT_INTERP;
        end
      end
      default: begin
      end
    endcase
  end

  // a result strobe only ever shows with the sequencer back at idle
  `TLIL_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result strobe while busy")
  // busy drops only together with a result
  `TLIL_ASSERT(a_fall_done, clk, rst, $fell(busy) |-> done, "busy dropped without a result")
  // a lookup transfer keeps the block busy
  `TLIL_ASSERT(a_lookup_busy, clk, rst,
    (accept && req.cmd == tlil_pkg::CMD_LOOKUP) |=> busy, "lookup transfer not taken")
  // a write transfer answers in the next cycle with write status
  `TLIL_ASSERT(a_write_ack, clk, rst,
    (accept && req.cmd == tlil_pkg::CMD_WRITE) |=> (done && rsp.status == tlil_pkg::STAT_WRITE),
    "write transfer not acknowledged")
  // the divider finishes only while the sequencer waits for it
  `TLIL_ASSERT(a_md_wait, clk, rst, md_done |-> (state == tlil_pkg::S_DIV),
    "divider result with no lookup waiting")

endmodule

FILE: sim/table_linear_interpolation_lookup_tb.sv
`timescale 1ns / 1ps

module table_linear_interpolation_lookup_tb;

  localparam logic signed [tlil_pkg::DATA_W-1:0] KEY_MIN =
    {1'b1, {(tlil_pkg::DATA_W-1){1'b0}}};
  localparam logic signed [tlil_pkg::DATA_W-1:0] KEY_MAX =
    {1'b0, {(tlil_pkg::DATA_W-1){1'b1}}};
  localparam int TAIL_CYCLES = 80;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  tlil_pkg::req_t req;
  logic done;
  tlil_pkg::rsp_t rsp;
  logic cfg_we;
  logic [tlil_pkg::CFG_W-1:0] cfg_data;

  table_linear_interpolation_lookup u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // shadow copy of the table and the entry count
  logic signed [tlil_pkg::DATA_W-1:0] tbl_key [tlil_pkg::TABLE_DEPTH];
  logic signed [tlil_pkg::DATA_W-1:0] tbl_val [tlil_pkg::TABLE_DEPTH];
  logic [tlil_pkg::CFG_W-1:0]         entry_count;

  tlil_pkg::rsp_t pending_results [$];
  int             mismatch_count;

  typedef struct {
    tlil_pkg::req_t item;
    bit             typed;
    tlil_pkg::rsp_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // expected answer for one transfer, updates the shadow table on a write
  function automatic tlil_pkg::rsp_t table_predict(input tlil_pkg::req_t item);
    tlil_pkg::rsp_t                     o;
    int                                 n;
    bit                                 lo_ok;
    bit                                 hi_ok;
    logic signed [tlil_pkg::DATA_W-1:0] k;
    logic signed [tlil_pkg::DATA_W-1:0] x1;
    logic signed [tlil_pkg::DATA_W-1:0] y1;
    logic signed [tlil_pkg::DATA_W-1:0] x2;
    logic signed [tlil_pkg::DATA_W-1:0] y2;
    logic [tlil_pkg::DATA_W:0]          d;
    logic [tlil_pkg::DATA_W:0]          t;
    logic [tlil_pkg::DATA_W:0]          dy;
    logic [127:0]                       quo;
    logic [tlil_pkg::DATA_W+1:0]        acc;
    o.result_value = '0;
    o.status       = tlil_pkg::STAT_WRITE;
    k = item.key;
    if (item.cmd == tlil_pkg::CMD_WRITE) begin
      tbl_key[item.entry_index] = item.key;
      tbl_val[item.entry_index] = item.entry_value;
      return o;
    end
    n = int'(entry_count);
    if (n < tlil_pkg::MIN_ENTRIES) n = tlil_pkg::MIN_ENTRIES;
    if (n > tlil_pkg::TABLE_DEPTH) n = tlil_pkg::TABLE_DEPTH;
    // exact hit, lowest index wins
    for (int i = 0; i < n; i++) begin
      if (tbl_key[i] == k) begin
        o.result_value = tbl_val[i];
        o.status       = tlil_pkg::STAT_HIT;
        return o;
      end
    end
    lo_ok = 1'b0;
    hi_ok = 1'b0;
    x1 = '0; y1 = '0; x2 = '0; y2 = '0;
    // nearest neighbours by key value, ties go to the lower index
    for (int i = 0; i < n; i++) begin
      if (tbl_key[i] < k) begin
        if (!lo_ok || tbl_key[i] > x1) begin
          lo_ok = 1'b1; x1 = tbl_key[i]; y1 = tbl_val[i];
        end
      end else begin
        if (!hi_ok || tbl_key[i] < x2) begin
          hi_ok = 1'b1; x2 = tbl_key[i]; y2 = tbl_val[i];
        end
      end
    end
    if (!lo_ok) begin
      o.result_value = y2;
      o.status       = tlil_pkg::STAT_BELOW;
      return o;
    end
    if (!hi_ok) begin
      o.result_value = y1;
      o.status       = tlil_pkg::STAT_ABOVE;
      return o;
    end
    o.status = tlil_pkg::STAT_INTERP;
    if (y1 == y2) begin
      o.result_value = y2;
      return o;
    end
    // differences are positive and fit in 49 bits
    d  = {x2[tlil_pkg::DATA_W-1], x2} - {x1[tlil_pkg::DATA_W-1], x1};
    t  = {k[tlil_pkg::DATA_W-1], k} - {x1[tlil_pkg::DATA_W-1], x1};
    dy = (y2 > y1) ? ({y2[tlil_pkg::DATA_W-1], y2} - {y1[tlil_pkg::DATA_W-1], y1})
                   : ({y1[tlil_pkg::DATA_W-1], y1} - {y2[tlil_pkg::DATA_W-1], y2});
    quo = (128'(dy) * 128'(t)) / 128'(d);
    if (y2 > y1) acc = {{2{y1[tlil_pkg::DATA_W-1]}}, y1} + quo[tlil_pkg::DATA_W+1:0];
    else         acc = {{2{y1[tlil_pkg::DATA_W-1]}}, y1} - quo[tlil_pkg::DATA_W+1:0];
    o.result_value = acc[tlil_pkg::DATA_W-1:0];
    return o;
  endfunction

  function automatic logic signed [tlil_pkg::DATA_W-1:0] fx(input longint v);
    return tlil_pkg::DATA_W'(v * 65536);
  endfunction

  function automatic logic signed [tlil_pkg::DATA_W-1:0] rand_word();
    return tlil_pkg::DATA_W'({$urandom(), $urandom()});
  endfunction

  // full-range word or a small sign-extended one
  function automatic logic signed [tlil_pkg::DATA_W-1:0] rand_data();
    logic signed [23:0] s;
    if ($urandom_range(0, 1) == 0) return rand_word();
    s = 24'($urandom());
    return tlil_pkg::DATA_W'(s);
  endfunction

  // mostly short gaps, a few long ones, none in a burst
  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // lookup key near the current table content
  function automatic logic signed [tlil_pkg::DATA_W-1:0] pick_lookup_key();
    int                                 r;
    int                                 i;
    logic signed [tlil_pkg::DATA_W-1:0] a;
    logic signed [tlil_pkg::DATA_W-1:0] b;
    logic [tlil_pkg::DATA_W:0]          span;
    logic [63:0]                        off;
    logic [tlil_pkg::DATA_W:0]          sum;
    r = $urandom_range(0, 99);
    if (r < 30) return tbl_key[$urandom_range(0, tlil_pkg::TABLE_DEPTH-1)];
    if (r < 72) begin
      i = $urandom_range(0, tlil_pkg::TABLE_DEPTH-2);
      a = (tbl_key[i] < tbl_key[i+1]) ? tbl_key[i] : tbl_key[i+1];
      b = (tbl_key[i] < tbl_key[i+1]) ? tbl_key[i+1] : tbl_key[i];
      span = {b[tlil_pkg::DATA_W-1], b} - {a[tlil_pkg::DATA_W-1], a};
      off  = {$urandom(), $urandom()} % (64'(span) + 64'd1);
      sum  = {a[tlil_pkg::DATA_W-1], a} + off[tlil_pkg::DATA_W:0];
      return sum[tlil_pkg::DATA_W-1:0];
    end
    if (r < 82) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return tbl_key[0] - 1;
        default: return tbl_key[tlil_pkg::TABLE_DEPTH-1] + 1;
      endcase
    end
    return rand_word();
  endfunction

  // one transfer: wait for busy low, then record what should come back
  task automatic send_item(input tlil_pkg::req_t item, input int gap, input bit typed,
                           input tlil_pkg::rsp_t want);
    tlil_pkg::rsp_t predicted;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
    predicted = table_predict(item);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic send_write(input int idx, input logic signed [tlil_pkg::DATA_W-1:0] k,
                            input logic signed [tlil_pkg::DATA_W-1:0] v, input int gap);
    tlil_pkg::req_t item;
    item.cmd         = tlil_pkg::CMD_WRITE;
    item.entry_index = tlil_pkg::IDX_IN_W'(idx);
    item.key         = k;
    item.entry_value = v;
    send_item(item, gap, 1'b0, '0);
  endtask

  // drop start and let every outstanding result arrive
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_entry_count(input int v);
    drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= tlil_pkg::CFG_W'(v);
    @(negedge clk);
    cfg_we   <= 1'b0;
    entry_count = tlil_pkg::CFG_W'(v);
  endtask

  task automatic add_row(input logic cmd, input int idx,
                         input logic signed [tlil_pkg::DATA_W-1:0] k,
                         input logic signed [tlil_pkg::DATA_W-1:0] v, input bit typed,
                         input logic signed [tlil_pkg::DATA_W-1:0] want_val,
                         input logic [tlil_pkg::STAT_W-1:0] want_stat);
    dir_row_t row;
    row.item.cmd           = cmd;
    row.item.entry_index   = tlil_pkg::IDX_IN_W'(idx);
    row.item.key           = k;
    row.item.entry_value   = v;
    row.typed              = typed;
    row.want.result_value  = want_val;
    row.want.status        = want_stat;
    dir_rows.push_back(row);
  endtask

  // rewrite the whole table with ascending random keys
  task automatic refill_sorted(input bit burst);
    logic signed [tlil_pkg::DATA_W-1:0] ks [tlil_pkg::TABLE_DEPTH];
    logic signed [tlil_pkg::DATA_W-1:0] tmp;
    logic signed [tlil_pkg::DATA_W-1:0] v;
    logic signed [tlil_pkg::DATA_W-1:0] prev_v;
    bit                                 narrow;
    narrow = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < tlil_pkg::TABLE_DEPTH; i++) begin
      if (narrow) ks[i] = tlil_pkg::DATA_W'(signed'(20'($urandom())));
      else        ks[i] = rand_word();
    end
    for (int i = 1; i < tlil_pkg::TABLE_DEPTH; i++) begin
      for (int j = i; j > 0 && ks[j-1] > ks[j]; j--) begin
        tmp = ks[j]; ks[j] = ks[j-1]; ks[j-1] = tmp;
      end
    end
    prev_v = '0;
    for (int i = 0; i < tlil_pkg::TABLE_DEPTH; i++) begin
      // equal neighbour values now and then
      if (i > 0 && $urandom_range(0, 4) == 0) v = prev_v;
      else                                     v = rand_data();
      send_write(i, ks[i], v, pick_gap(burst));
      prev_v = v;
    end
  endtask

  // result checker, the receiver never stalls
  always @(posedge clk) begin
    tlil_pkg::rsp_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no transfer pending: result_value %0d status %0d",
               $signed(rsp.result_value), rsp.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.result_value !== want.result_value) begin
          $error("result_value mismatch: expected %0d actual %0d",
                 $signed(want.result_value), $signed(rsp.result_value));
          mismatch_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status mismatch: expected %0d actual %0d", want.status, rsp.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int             phase_cfg [9];
    bit             burst;
    tlil_pkg::req_t item;
    mismatch_count = 0;
    entry_count    = tlil_pkg::ENTRIES_RESET;
    rst      = 1'b1;
    start    = 1'b0;
    req      = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    for (int i = 0; i < tlil_pkg::TABLE_DEPTH; i++) begin
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // every entry written before any lookup: keys -8..7, values 0..15
    for (int i = 0; i < tlil_pkg::TABLE_DEPTH; i++) begin
      send_write(i, fx(i - 8), fx(i), pick_gap(1'b0));
    end

    // directed rows at the reset entry count of 14
    add_row(tlil_pkg::CMD_LOOKUP, 0, KEY_MIN, '0, 1, fx(0), tlil_pkg::STAT_BELOW);
    add_row(tlil_pkg::CMD_LOOKUP, 15, KEY_MAX, '0, 1, fx(13), tlil_pkg::STAT_ABOVE);
    add_row(tlil_pkg::CMD_LOOKUP, 0, fx(-8), '0, 1, fx(0), tlil_pkg::STAT_HIT);
    add_row(tlil_pkg::CMD_LOOKUP, 0, fx(5), KEY_MIN, 1, fx(13), tlil_pkg::STAT_HIT);
    add_row(tlil_pkg::CMD_LOOKUP, 0, tlil_pkg::DATA_W'(-64'sd491520), KEY_MAX, 0, '0,
            tlil_pkg::STAT_INTERP);
    add_row(tlil_pkg::CMD_LOOKUP, 0, tlil_pkg::DATA_W'(64'sd278528), '0, 0, '0,
            tlil_pkg::STAT_INTERP);
    // entry 14 lies past the entries in use
    add_row(tlil_pkg::CMD_LOOKUP, 0, fx(6), '0, 1, fx(13), tlil_pkg::STAT_ABOVE);
    add_row(tlil_pkg::CMD_WRITE, 0, KEY_MIN, KEY_MAX, 1, '0, tlil_pkg::STAT_WRITE);
    add_row(tlil_pkg::CMD_WRITE, 13, KEY_MAX, KEY_MIN, 1, '0, tlil_pkg::STAT_WRITE);
    add_row(tlil_pkg::CMD_LOOKUP, 0, KEY_MIN, '0, 1, KEY_MAX, tlil_pkg::STAT_HIT);
    add_row(tlil_pkg::CMD_LOOKUP, 0, KEY_MAX, '0, 1, KEY_MIN, tlil_pkg::STAT_HIT);
    // widest spans, largest products
    add_row(tlil_pkg::CMD_LOOKUP, 0, KEY_MIN + 1, '0, 0, '0, tlil_pkg::STAT_INTERP);
    add_row(tlil_pkg::CMD_LOOKUP, 0, KEY_MAX - 1, '0, 0, '0, tlil_pkg::STAT_INTERP);
    // out-of-order table
    add_row(tlil_pkg::CMD_WRITE, 5, fx(100), tlil_pkg::DATA_W'(7), 1, '0,
            tlil_pkg::STAT_WRITE);
    add_row(tlil_pkg::CMD_LOOKUP, 0, fx(50), '0, 0, '0, tlil_pkg::STAT_INTERP);
    // duplicate key, the lower index answers
    add_row(tlil_pkg::CMD_WRITE, 6, fx(100), tlil_pkg::DATA_W'(9), 1, '0,
            tlil_pkg::STAT_WRITE);
    add_row(tlil_pkg::CMD_LOOKUP, 0, fx(100), '0, 1, tlil_pkg::DATA_W'(7),
            tlil_pkg::STAT_HIT);
    // equal neighbour values
    add_row(tlil_pkg::CMD_WRITE, 2, fx(-6), fx(3), 1, '0, tlil_pkg::STAT_WRITE);
    add_row(tlil_pkg::CMD_LOOKUP, 0, tlil_pkg::DATA_W'(-64'sd360448), '0, 1, fx(3),
            tlil_pkg::STAT_INTERP);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, pick_gap(1'b0), dir_rows[i].typed, dir_rows[i].want);
    end

    // random phases, entry counts below, at and above the legal range
    phase_cfg = '{0, 2, 16, 31, 1, 17, 14, 5, 9};
    phase_cfg[8] = $urandom_range(0, 31);
    foreach (phase_cfg[p]) begin
      write_entry_count(phase_cfg[p]);
      burst = ($urandom_range(0, 2) == 0);
      refill_sorted(burst);
      repeat (74) begin
        if ($urandom_range(0, 99) < 15) begin
          // stray write that can break the ordering
          item.cmd         = tlil_pkg::CMD_WRITE;
          item.entry_index = tlil_pkg::IDX_IN_W'($urandom());
          item.key         = ($urandom_range(0, 1) == 0) ? pick_lookup_key() : rand_word();
          item.entry_value = rand_data();
        end else begin
          item.cmd         = tlil_pkg::CMD_LOOKUP;
          item.entry_index = tlil_pkg::IDX_IN_W'($urandom());
          item.key         = pick_lookup_key();
          item.entry_value = rand_word();
        end
        send_item(item, pick_gap(burst), 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
